### rtl/psc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Point set conditioning package
// Shared constants and types for the conditioning core.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int MaxPoints  = 64;
    localparam int CoordFrac  = 4;
    localparam int ScaleFrac  = 28;
    localparam int OffsetFrac = 24;
    localparam int CoordW     = 20;
    localparam int AddrW      = $clog2(MaxPoints);
    localparam int CountW     = $clog2(MaxPoints + 1);
    localparam int SumW       = CoordW + AddrW;
    // n*v - S fits in SumW + AddrW + 2 bits; D adds AddrW more
    localparam int ProdW      = SumW + AddrW + 2;
    localparam int DevW       = ProdW + AddrW;
    localparam int NumW       = 64;
    localparam int QuotW      = 64;

    // Entry in the queue between the loader and the solver
    typedef struct packed {
        logic signed [SumW-1:0] sum_x;
        logic signed [SumW-1:0] sum_y;
        logic [CountW-1:0]      count;
        logic                   dropped;
    } set_desc_t;

endpackage
`default_nettype wire

### rtl/psc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Point set conditioning divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psc_divider
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         go,
    input  wire logic [psc_pkg::NumW-1:0]     numer,
    input  wire logic [psc_pkg::DevW-1:0]     denom,
    output logic                              done,
    output logic [psc_pkg::QuotW-1:0]         quot,
    output logic [psc_pkg::DevW-1:0]          rem
);

    localparam int StepW = $clog2(psc_pkg::NumW + 1);

    logic [StepW-1:0]          step_reg, step_next;
    logic                      run_reg, run_next;
    logic [psc_pkg::NumW-1:0]  q_reg, q_next;
    logic [psc_pkg::DevW:0]    r_reg, r_next;
    logic [psc_pkg::DevW-1:0]  d_reg, d_next;
    logic                      done_reg, done_next;
    logic [psc_pkg::DevW:0]    trial;

    // One shift and trial subtract per cycle.
    always_comb
    begin
        step_next = step_reg;
        run_next  = run_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        trial     = {r_reg[psc_pkg::DevW-1:0], q_reg[psc_pkg::NumW-1]};
        if (go)
        begin
            run_next  = 1'b1;
            step_next = StepW'(psc_pkg::NumW);
            q_next    = numer;
            r_next    = '0;
            d_next    = denom;
        end
        else if (run_reg)
        begin
            q_next = {q_reg[psc_pkg::NumW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            step_next = step_reg - 1'b1;
            if (step_reg == StepW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg[psc_pkg::DevW-1:0];

endmodule
`default_nettype wire

### rtl/psc_loader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Point set conditioning loader
// Accepts points, stores them, keeps sums and hands finished sets onwards.
// ----------------------------------------------------------------------------
module psc_loader
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                take,
    input  wire logic signed [psc_pkg::CoordW-1:0]   point_x,
    input  wire logic signed [psc_pkg::CoordW-1:0]   point_y,
    input  wire logic                                last_point,
    output logic                                     wr_en,
    output logic [psc_pkg::AddrW-1:0]                wr_addr,
    output logic signed [psc_pkg::CoordW-1:0]        wr_x,
    output logic signed [psc_pkg::CoordW-1:0]        wr_y,
    output logic                                     set_valid,
    output psc_pkg::set_desc_t                       set_desc
);

    logic signed [psc_pkg::SumW-1:0] sum_x_reg, sum_x_next;
    logic signed [psc_pkg::SumW-1:0] sum_y_reg, sum_y_next;
    logic [psc_pkg::CountW-1:0]      count_reg, count_next;
    logic                            drop_reg, drop_next;
    logic                            room;

    // Store the point while there is room, then close the set on the last one.
    always_comb
    begin
        room       = (count_reg != psc_pkg::CountW'(psc_pkg::MaxPoints));
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        set_valid  = 1'b0;
        set_desc   = '0;
        if (take)
        begin
            if (room)
            begin
                sum_x_next = sum_x_reg + psc_pkg::SumW'(point_x);
                sum_y_next = sum_y_reg + psc_pkg::SumW'(point_y);
                count_next = count_reg + 1'b1;
            end
            else
            begin
                drop_next = 1'b1;
            end
            if (last_point)
            begin
                set_valid        = 1'b1;
                set_desc.sum_x   = sum_x_next;
                set_desc.sum_y   = sum_y_next;
                set_desc.count   = count_next;
                set_desc.dropped = drop_next;
                sum_x_next       = '0;
                sum_y_next       = '0;
                count_next       = '0;
                drop_next        = 1'b0;
            end
        end
    end

    assign wr_en   = take && room;
    assign wr_addr = count_reg[psc_pkg::AddrW-1:0];
    assign wr_x    = point_x;
    assign wr_y    = point_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

endmodule
`default_nettype wire

### rtl/psc_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Point set conditioning solver
// Deviation pass over the store, then, unless the set is degenerate, four divisions and saturation.
// ----------------------------------------------------------------------------
module psc_solver
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire logic [psc_pkg::AddrW-1:0]           wr_addr,
    input  wire logic signed [psc_pkg::CoordW-1:0]   wr_x,
    input  wire logic signed [psc_pkg::CoordW-1:0]   wr_y,
    input  wire logic                                job_valid,
    input  wire psc_pkg::set_desc_t                  job,
    output logic                                     idle,
    output logic                                     done,
    output logic [30:0]                              scale_x,
    output logic [31:0]                              offset_x,
    output logic [30:0]                              scale_y,
    output logic [31:0]                              offset_y,
    output logic                                     degenerate,
    output logic                                     overflowed,
    output logic                                     saturated
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DEV  = 6'b000010,
        ST_DRN  = 6'b000100,
        ST_DGO  = 6'b001000,
        ST_DWT  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    localparam int PW  = psc_pkg::ProdW;
    localparam int DW  = psc_pkg::DevW;
    localparam int SqW = 2 * psc_pkg::CountW;
    localparam int ScW = psc_pkg::SumW + psc_pkg::CountW;

    state_t                          state_reg, state_next;
    psc_pkg::set_desc_t              job_reg;
    logic [psc_pkg::CountW-1:0]      idx_reg;
    logic [1:0]                      div_sel_reg;
    logic [DW-1:0]                   dx_reg, dy_reg;
    logic                            rd_valid_reg, prod_valid_reg;
    logic signed [psc_pkg::CoordW-1:0] rx_reg, ry_reg;
    logic signed [PW-1:0]            px_reg, py_reg;
    logic [30:0]                     sx_reg, sy_reg;
    logic [31:0]                     ox_reg, oy_reg;
    logic                            sat_reg, done_reg;
    logic [psc_pkg::NumW-1:0]        numer;
    logic [DW-1:0]                   denom;
    logic                            div_go, div_done;
    logic [psc_pkg::QuotW-1:0]       quot;
    logic [DW-1:0]                   rem;
    logic [psc_pkg::QuotW-1:0]       qr;
    logic                            round_up;
    logic signed [psc_pkg::SumW-1:0] cur_sum;
    logic [psc_pkg::SumW-1:0]        sum_mag;
    logic [DW-1:0]                   cur_d;
    logic [SqW-1:0]                  cnt_sq;
    logic [ScW-1:0]                  sum_cnt;
    logic signed [PW-1:0]            nx, ny;

    // Point store, written by the loader and swept by the deviation pass.
    logic signed [psc_pkg::CoordW-1:0] mem_x [psc_pkg::MaxPoints];
    logic signed [psc_pkg::CoordW-1:0] mem_y [psc_pkg::MaxPoints];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
        rx_reg <= mem_x[idx_reg[psc_pkg::AddrW-1:0]];
        ry_reg <= mem_y[idx_reg[psc_pkg::AddrW-1:0]];
    end

    // Products n*v - S, one point per cycle, registered before accumulation.
    always_comb
    begin
        nx = PW'($signed({1'b0, job_reg.count})) * PW'(rx_reg) - PW'(job_reg.sum_x);
        ny = PW'($signed({1'b0, job_reg.count})) * PW'(ry_reg) - PW'(job_reg.sum_y);
    end

    always_ff @(posedge clk)
    begin
        px_reg <= nx;
        py_reg <= ny;
    end

    // Operand selection for the shared divider: scale x, offset x, scale y, offset y.
    always_comb
    begin
        cur_sum = div_sel_reg[1] ? job_reg.sum_y : job_reg.sum_x;
        cur_d   = div_sel_reg[1] ? dy_reg : dx_reg;
        sum_mag = cur_sum[psc_pkg::SumW-1] ? psc_pkg::SumW'(-cur_sum)
                                            : psc_pkg::SumW'(cur_sum);
        cnt_sq  = SqW'(job_reg.count) * SqW'(job_reg.count);
        sum_cnt = ScW'(sum_mag) * ScW'(job_reg.count);
        if (!div_sel_reg[0])
        begin
            numer = psc_pkg::NumW'(cnt_sq);
            numer = numer << (psc_pkg::CoordFrac + psc_pkg::ScaleFrac);
        end
        else
        begin
            numer = psc_pkg::NumW'(sum_cnt);
            numer = numer << psc_pkg::OffsetFrac;
        end
        denom = cur_d;
        // Round half away from zero: remainder at least the upper half of d
        round_up = (rem >= cur_d - (cur_d >> 1));
        qr       = quot + psc_pkg::QuotW'(round_up);
    end

    psc_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .numer (numer),
        .denom (denom),
        .done  (div_done),
        .quot  (quot),
        .rem   (rem)
    );

    assign div_go = (state_reg == ST_DGO);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_DEV;
            ST_DEV:  if (idx_reg == job_reg.count) state_next = ST_DRN;
            ST_DRN:  if (!rd_valid_reg && !prod_valid_reg)
                     begin
                         if (dx_reg == '0 || dy_reg == '0) state_next = ST_OUT;
                         else                              state_next = ST_DGO;
                     end
            ST_DGO:  state_next = ST_DWT;
            ST_DWT:  if (div_done)
                     begin
                         if (div_sel_reg == 2'd3) state_next = ST_OUT;
                         else                     state_next = ST_DGO;
                     end
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            div_sel_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            sat_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= (state_reg == ST_OUT);
            rd_valid_reg   <= (state_reg == ST_DEV) && (idx_reg != job_reg.count);
            prod_valid_reg <= rd_valid_reg;
            if (state_reg == ST_IDLE)
            begin
                idx_reg     <= '0;
                div_sel_reg <= '0;
                sat_reg     <= 1'b0;
            end
            else if (state_reg == ST_DEV && idx_reg != job_reg.count)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (state_reg == ST_DWT && div_done)
            begin
                div_sel_reg <= div_sel_reg + 1'b1;
                if (!div_sel_reg[0])
                begin
                    if (qr > psc_pkg::QuotW'(32'h7FFF_FFFF)) sat_reg <= 1'b1;
                end
                else if (cur_sum > 0)
                begin
                    if (qr > psc_pkg::QuotW'(32'h8000_0000)) sat_reg <= 1'b1;
                end
                else if (qr > psc_pkg::QuotW'(32'h7FFF_FFFF))
                begin
                    sat_reg <= 1'b1;
                end
            end
        end
    end

    // Set descriptor, deviation sums and results.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            job_reg <= job;
            dx_reg  <= '0;
            dy_reg  <= '0;
        end
        else if (prod_valid_reg)
        begin
            dx_reg <= dx_reg + DW'(px_reg[PW-1] ? -px_reg : px_reg);
            dy_reg <= dy_reg + DW'(py_reg[PW-1] ? -py_reg : py_reg);
        end
        if (state_reg == ST_DRN)
        begin
            sx_reg <= 31'h1000_0000;
            sy_reg <= 31'h1000_0000;
            ox_reg <= '0;
            oy_reg <= '0;
        end
        if (state_reg == ST_DWT && div_done)
        begin
            case (div_sel_reg)
                2'd0: sx_reg <= (qr > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : qr[30:0];
                2'd2: sy_reg <= (qr > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : qr[30:0];
                default:
                begin
                    if (div_sel_reg[1])
                    begin
                        if (cur_sum > 0)
                            oy_reg <= (qr > 64'h8000_0000) ? 32'h8000_0000 : 32'(-qr);
                        else
                            oy_reg <= (qr > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qr[31:0];
                    end
                    else
                    begin
                        if (cur_sum > 0)
                            ox_reg <= (qr > 64'h8000_0000) ? 32'h8000_0000 : 32'(-qr);
                        else
                            ox_reg <= (qr > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qr[31:0];
                    end
                end
            endcase
        end
    end

    assign idle       = (state_reg == ST_IDLE);
    assign done       = done_reg;
    assign scale_x    = sx_reg;
    assign scale_y    = sy_reg;
    assign offset_x   = ox_reg;
    assign offset_y   = oy_reg;
    assign degenerate = (dx_reg == '0) || (dy_reg == '0);
    assign overflowed = job_reg.dropped;
    assign saturated  = sat_reg;

endmodule
`default_nettype wire

### rtl/point_set_conditioning_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Point set conditioning core
// Conditioning transform (scale and offset per axis) of a 2D point set.
// ----------------------------------------------------------------------------
// Usage: drive point_x, point_y and last_point with start high; a transfer
// takes place at each rising edge where start is high and busy is low.
// Points load at one per cycle, while busy is low, into a 64-entry store;
// further points of a set are dropped and reported through overflowed.
// A point with last_point closes the set and is queued for the solver.
// The solver sweeps the store once, then runs four divisions in turn on
// one shared restoring divider before done rises. Degenerate sets skip
// the divisions.
// busy is high while a closed set waits in the queue or the solver is
// working, since the solver reads the shared store; the next set loads
// once the solver is idle again.
// done pulses for one cycle with all result ports valid; the receiver
// cannot stall. Reset clears all control state; the store needs none.
// ----------------------------------------------------------------------------
module point_set_conditioning_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [psc_pkg::CoordW-1:0]   point_x,
    input  wire logic signed [psc_pkg::CoordW-1:0]   point_y,
    input  wire logic                                last_point,
    output logic                                     done,
    output logic [30:0]                              scale_x,
    output logic [31:0]                              offset_x,
    output logic [30:0]                              scale_y,
    output logic [31:0]                              offset_y,
    output logic                                     degenerate,
    output logic                                     overflowed,
    output logic                                     saturated
);

    logic                              take;
    logic                              wr_en;
    logic [psc_pkg::AddrW-1:0]         wr_addr;
    logic signed [psc_pkg::CoordW-1:0] wr_x, wr_y;
    logic                              set_valid, solver_idle;
    psc_pkg::set_desc_t                set_desc, q_desc_reg;
    logic                              q_full_reg;

    // The queue holds one closed set; the store is busy while it is occupied,
    // since the solver still has to read the stored points.
    assign busy = q_full_reg || !solver_idle;
    assign take = start && !busy;

    psc_loader u_loader
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_x       (wr_x),
        .wr_y       (wr_y),
        .set_valid  (set_valid),
        .set_desc   (set_desc)
    );

    // One-entry queue between the loader and the solver.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_full_reg <= 1'b0;
        end
        else if (set_valid)
        begin
            q_full_reg <= 1'b1;
        end
        else if (solver_idle)
        begin
            q_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (set_valid)
        begin
            q_desc_reg <= set_desc;
        end
    end

    psc_solver u_solver
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_x       (wr_x),
        .wr_y       (wr_y),
        .job_valid  (q_full_reg),
        .job        (q_desc_reg),
        .idle       (solver_idle),
        .done       (done),
        .scale_x    (scale_x),
        .offset_x   (offset_x),
        .scale_y    (scale_y),
        .offset_y   (offset_y),
        .degenerate (degenerate),
        .overflowed (overflowed),
        .saturated  (saturated)
    );

endmodule
`default_nettype wire
